// ----- hdl/fke_pkg.sv -----
// fke_pkg: shared types and constants of the FASTA k-mer extractor.
// Depends on nothing; used by fasta_kmer_extractor_unit.
package fke_pkg;

  // Fixed port widths
  localparam int unsigned CharW = 8;
  localparam int unsigned KmerW = 64;
  localparam int unsigned KlenW = 6;

  // Default sizing
  localparam int unsigned MaxKDefault = 32;
  localparam logic [KlenW-1:0] KlenReset = 6'd31;

  // Characters of interest
  localparam logic [CharW-1:0] ChNewline = 8'd10;
  localparam logic [CharW-1:0] ChSpace   = 8'h20;
  localparam logic [CharW-1:0] ChHeader  = 8'h3E;  // '>'
  localparam logic [CharW-1:0] ChBaseA   = 8'h41;
  localparam logic [CharW-1:0] ChBaseC   = 8'h43;
  localparam logic [CharW-1:0] ChBaseG   = 8'h47;
  localparam logic [CharW-1:0] ChBaseN   = 8'h4E;
  localparam logic [CharW-1:0] ChBaseT   = 8'h54;

  typedef enum logic [1:0] {
    LsStart = 2'd0,
    LsData  = 2'd1,
    LsSkip  = 2'd2
  } line_state_e;

  typedef logic [1:0] base_code_t;

  // 2-bit base code; anything but C, G, T counts as A
  function automatic base_code_t base_code(input logic [CharW-1:0] c);
    base_code_t code;
    unique case (c)
      ChBaseC: code = 2'd1;
      ChBaseG: code = 2'd2;
      ChBaseT: code = 2'd3;
      default: code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/fasta_kmer_extractor_unit.sv -----
// fasta_kmer_extractor_unit: streams FASTA text and emits packed K-base windows.
// Depends on fke_pkg (constants, line state type, base encoding).
//
//   port group   dir  handshake               payload
//   in           in   in_valid_i / in_ready_o  ch_i      (8 bits)
//   out          out  out_valid_o / out_ready_i kmer_o   (64 bits)
//   cfg          in   cfg_we_i (no wait)       cfg_wdata_i (6 bits, K)
//
// One byte per cycle unless a result stalls at the output; each byte waits in the
// input register; any result goes to the result register as the byte leaves.
// Reset clears window, base count and line state and sets K to 31.
// The input register keeps taking one byte while a result waits in the result
// register; bytes that yield no result pass through even under output stall.
module fasta_kmer_extractor_unit #(
  parameter int unsigned MaxK = fke_pkg::MaxKDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [fke_pkg::CharW-1:0] ch_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [fke_pkg::KmerW-1:0] kmer_o,
  input  logic                      cfg_we_i,
  input  logic [fke_pkg::KlenW-1:0] cfg_wdata_i
);

  localparam int unsigned WinW = 2 * MaxK;
  localparam int unsigned CntW = $clog2(MaxK + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxK);

  // Configuration
  logic [fke_pkg::KlenW-1:0] klen_q;
  logic [CntW-1:0]           k_eff;

  // Input register
  logic                      s1_valid_q;
  logic [fke_pkg::CharW-1:0] s1_ch_q;
  logic                      s1_fire;

  // Read state
  logic [WinW-1:0]      window_q, window_d;
  logic [CntW-1:0]      base_cnt_q, base_cnt_d;
  fke_pkg::line_state_e line_q, line_d;

  logic add_base, clear_read;
  logic has_result;
  logic [WinW-1:0] mask;

  // Result register
  logic                      out_valid_q;
  logic [fke_pkg::KmerW-1:0] kmer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= fke_pkg::KlenReset;
    end else if (cfg_we_i) begin
      klen_q <= cfg_wdata_i;
    end
  end

  // Clamp K into 1..MaxK
  always_comb begin
    if (klen_q == '0) begin
      k_eff = CntW'(1);
    end else if (32'(klen_q) > MaxK) begin
      k_eff = CntMax;
    end else begin
      k_eff = klen_q[CntW-1:0];
    end
  end

  // Next line state
  always_comb begin
    line_d = line_q;
    if (s1_ch_q == fke_pkg::ChNewline) begin
      line_d = fke_pkg::LsStart;
    end else begin
      unique case (line_q)
        fke_pkg::LsStart: begin
          if (s1_ch_q == fke_pkg::ChHeader || s1_ch_q == fke_pkg::ChSpace) begin
            line_d = fke_pkg::LsSkip;
          end else begin
            line_d = fke_pkg::LsData;
          end
        end
        fke_pkg::LsData: line_d = fke_pkg::LsData;
        default:         line_d = fke_pkg::LsSkip;
      endcase
    end
  end

  // Actions of the current byte
  always_comb begin
    add_base   = 1'b0;
    clear_read = 1'b0;
    if (s1_ch_q != fke_pkg::ChNewline) begin
      unique case (line_q)
        fke_pkg::LsStart: begin
          if (s1_ch_q == fke_pkg::ChHeader) begin
            clear_read = 1'b1;
          end else if (s1_ch_q != fke_pkg::ChSpace) begin
            add_base = (s1_ch_q != fke_pkg::ChBaseN);
          end
        end
        fke_pkg::LsData: add_base = (s1_ch_q != fke_pkg::ChBaseN);
        default: begin
          add_base   = 1'b0;
          clear_read = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    window_d   = window_q;
    base_cnt_d = base_cnt_q;
    if (clear_read) begin
      window_d   = '0;
      base_cnt_d = '0;
    end else if (add_base) begin
      window_d = (window_q << 2) | WinW'(fke_pkg::base_code(s1_ch_q));
      if (base_cnt_q != CntMax) begin
        base_cnt_d = base_cnt_q + CntW'(1);
      end
    end
  end

  always_comb begin
    for (int unsigned i = 0; i < WinW; i++) begin
      mask[i] = (CntW'(i / 2) < k_eff);
    end
  end

  assign has_result = add_base && (base_cnt_d >= k_eff);

  // Advance when the result slot is free, or when the byte yields nothing
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i || !has_result);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_ch_q <= ch_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      base_cnt_q <= '0;
      line_q     <= fke_pkg::LsStart;
    end else if (s1_fire) begin
      window_q   <= window_d;
      base_cnt_q <= base_cnt_d;
      line_q     <= line_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      kmer_q <= fke_pkg::KmerW'(window_d & mask);
    end
  end

  assign out_valid_o = out_valid_q;
  assign kmer_o      = kmer_q;

  // Count saturates at MaxK
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_cnt_q <= CntMax)
    else $error("base count above MaxK");

  // Header at line start clears the read
  a_header_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && line_q == fke_pkg::LsStart && s1_ch_q == fke_pkg::ChHeader
    |=> base_cnt_q == '0 && window_q == '0)
    else $error("header did not clear the read");

  // Read state moves only when a byte leaves the input register
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(base_cnt_q) && $stable(line_q))
    else $error("read state changed without a byte");

  // A pending, stalled result is never overwritten
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(s1_fire && has_result))
    else $error("pending result overwritten");

endmodule
